// ----- hw/rtl/dbbc_pkg.sv -----
`timescale 1ns / 1ps

package dbbc_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FORMAT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STRIDE = 8'd1;

    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    typedef struct packed {
        logic [63:0] alpha_word;
        logic [63:0] colour_word;
        logic        last_block;
    } in_item_t;

    typedef struct packed {
        logic lit;
        logic dark;
        logic clear;
    } out_item_t;

    // per-block summary passed from front to back
    typedef struct packed {
        logic clear;
        logic bright;
        logic last;
    } cls_t;

endpackage

// ----- hw/rtl/dbbc_front.sv -----
`timescale 1ns / 1ps

module dbbc_front
    import dbbc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  block_format,
    input  logic [15:0] sample_stride,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        push,
    output cls_t        push_data,
    input  logic        push_ready
);

    localparam logic [10:0] LIM_DIV7 = 11'd1785; // floor(x/7) < 255
    localparam logic [10:0] LIM_DIV5 = 11'd1275; // floor(x/5) < 255

    logic [15:0] skip_reg, skip_next;
    logic [16:0] skip_inc;
    logic [15:0] stride_eff;
    logic        examine;
    logic        is_dxt1;
    logic        cl_raw;
    logic        br_raw;

    function automatic logic chan_above(input logic [7:0] num, input logic [1:0] den,
                                        input logic [5:0] maxv);
        logic [16:0] lhs;
        logic [16:0] rhs;
        lhs = 17'(num) * 17'd255;
        rhs = 17'(den) * 17'd8 * 17'(maxv);
        return lhs > rhs;
    endfunction

    function automatic logic [3:0] chan_hot(input logic [5:0] e0, input logic [5:0] e1,
                                            input logic [5:0] maxv, input logic four);
        logic [3:0] h;
        logic [7:0] s0, s1;
        s0 = 8'(e0);
        s1 = 8'(e1);
        h[0] = chan_above(s0, 2'd1, maxv);
        h[1] = chan_above(s1, 2'd1, maxv);
        if (four) begin
            h[2] = chan_above((s0 << 1) + s1, 2'd3, maxv);
            h[3] = chan_above(s0 + (s1 << 1), 2'd3, maxv);
        end else begin
            h[2] = chan_above(s0 + s1, 2'd2, maxv);
            h[3] = 1'b0;
        end
        return h;
    endfunction

    function automatic logic colour_bright(input logic [63:0] blk, input logic punchable);
        logic [15:0] c0, c1;
        logic [31:0] idx;
        logic        four;
        logic [3:0]  hot;
        logic        any;
        c0   = blk[15:0];
        c1   = blk[31:16];
        idx  = blk[63:32];
        four = (c0 > c1) || !punchable;
        hot  = chan_hot({1'b0, c0[15:11]}, {1'b0, c1[15:11]}, 6'd31, four)
             | chan_hot(c0[10:5], c1[10:5], 6'd63, four)
             | chan_hot({1'b0, c0[4:0]}, {1'b0, c1[4:0]}, 6'd31, four);
        any  = 1'b0;
        for (int t = 0; t < 16; t++) begin
            any = any | hot[idx[2*t +: 2]];
        end
        return any;
    endfunction

    function automatic logic punched(input logic [63:0] blk);
        logic any;
        any = 1'b0;
        for (int t = 0; t < 16; t++) begin
            any = any | (blk[32 + 2*t +: 2] == 2'd3);
        end
        return any && !(blk[15:0] > blk[31:16]);
    endfunction

    function automatic logic explicit_clear(input logic [63:0] a);
        logic any;
        any = 1'b0;
        for (int t = 0; t < 16; t++) begin
            any = any | (a[4*t +: 4] != 4'hF);
        end
        return any;
    endfunction

    function automatic logic interp_clear(input logic [63:0] a);
        logic [7:0]  a0, a1;
        logic [7:0]  lo;
        logic [10:0] num;
        logic        any;
        a0 = a[7:0];
        a1 = a[15:8];
        lo = '0;
        lo[0] = a0 != 8'd255;
        lo[1] = a1 != 8'd255;
        if (a0 > a1) begin
            for (int k = 0; k < 6; k++) begin
                num = 11'(6 - k) * 11'(a0) + 11'(1 + k) * 11'(a1);
                lo[2 + k] = num < LIM_DIV7;
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                num = 11'(4 - k) * 11'(a0) + 11'(1 + k) * 11'(a1);
                lo[2 + k] = num < LIM_DIV5;
            end
            lo[6] = 1'b1;
            lo[7] = 1'b0;
        end
        any = 1'b0;
        for (int t = 0; t < 16; t++) begin
            any = any | lo[a[16 + 3*t +: 3]];
        end
        return any;
    endfunction

    assign s_ready    = push_ready;
    assign push       = s_valid && push_ready;
    assign examine    = skip_reg == 16'd0;
    assign is_dxt1    = block_format == FMT_DXT1;
    assign stride_eff = (sample_stride == 16'd0) ? 16'd1 : sample_stride;
    assign skip_inc   = 17'(skip_reg) + 17'd1;

    always_comb begin
        case (block_format)
            FMT_DXT1: cl_raw = punched(s_data.alpha_word);
            FMT_DXT3: cl_raw = explicit_clear(s_data.alpha_word);
            FMT_DXT5: cl_raw = interp_clear(s_data.alpha_word);
            default:  cl_raw = interp_clear(s_data.alpha_word);
        endcase
        br_raw = colour_bright(is_dxt1 ? s_data.alpha_word : s_data.colour_word, is_dxt1);
    end

    assign push_data.clear  = examine && cl_raw;
    assign push_data.bright = examine && br_raw;
    assign push_data.last   = s_data.last_block;

    always_comb begin
        skip_next = skip_reg;
        if (push) begin
            if (s_data.last_block || (skip_inc >= 17'(stride_eff))) begin
                skip_next = 16'd0;
            end else begin
                skip_next = skip_inc[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= 16'd0;
        end else begin
            skip_reg <= skip_next;
        end
    end

endmodule

// ----- hw/rtl/dbbc_queue.sv -----
`timescale 1ns / 1ps

module dbbc_queue
    import dbbc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_en,
    input  cls_t wr_data,
    output logic wr_ready,
    input  logic rd_en,
    output cls_t rd_data,
    output logic rd_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cls_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign wr_ready = cnt_reg != CNT_W'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/dbbc_back.sv -----
`timescale 1ns / 1ps

module dbbc_back
    import dbbc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  cls_t      q_data,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      seen_clear_reg, seen_clear_next;
    logic      seen_bright_reg, seen_bright_next;
    logic      valid_reg, valid_next;
    out_item_t data_reg, data_next;
    logic      clr_any, br_any;

    assign q_pop   = q_valid && (!valid_reg || m_ready);
    assign clr_any = seen_clear_reg || q_data.clear;
    assign br_any  = seen_bright_reg || q_data.bright;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_comb begin
        seen_clear_next  = seen_clear_reg;
        seen_bright_next = seen_bright_reg;
        valid_next       = valid_reg && !m_ready;
        data_next        = data_reg;
        if (q_pop) begin
            if (q_data.last) begin
                seen_clear_next  = 1'b0;
                seen_bright_next = 1'b0;
                valid_next       = 1'b1;
                data_next.lit    = !clr_any && br_any;
                data_next.dark   = !clr_any && !br_any;
                data_next.clear  = clr_any;
            end else begin
                seen_clear_next  = clr_any;
                seen_bright_next = br_any;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_clear_reg  <= 1'b0;
            seen_bright_reg <= 1'b0;
            valid_reg       <= 1'b0;
        end else begin
            seen_clear_reg  <= seen_clear_next;
            seen_bright_reg <= seen_bright_next;
            valid_reg       <= valid_next;
        end
    end

endmodule

// ----- hw/rtl/dxt_block_brightness_classifier.sv -----
// Output: m_valid rises after the last item of a texture passes the queue and
// the back's result register, or later while a held result waits on m_ready.
// Throughput: one item per cycle unless stalled; the front decodes a whole block
// combinationally, and the back folds one queue entry per cycle unless stalled.
// Reset (aresetn low, synchronous) empties the queue, drops the output,
// clears the block counter and flags, and sets DXT1 with stride 1.
`timescale 1ns / 1ps

module dxt_block_brightness_classifier
    import dbbc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    logic [1:0]  fmt_reg;
    logic [15:0] stride_reg;
    logic        push, push_ready;
    cls_t        push_data;
    logic        q_valid, q_pop;
    cls_t        q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg    <= FMT_DXT1;
            stride_reg <= 16'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BLOCK_FORMAT:  fmt_reg    <= cfg_data[1:0];
                REG_SAMPLE_STRIDE: stride_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    dbbc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .block_format  (fmt_reg),
        .sample_stride (stride_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .push          (push),
        .push_data     (push_data),
        .push_ready    (push_ready)
    );

    dbbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (push),
        .wr_data  (push_data),
        .wr_ready (push_ready),
        .rd_en    (q_pop),
        .rd_data  (q_data),
        .rd_valid (q_valid)
    );

    dbbc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- hw/rtl/dbbc_checker.sv -----
`timescale 1ns / 1ps

module dbbc_checker
    import dbbc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  s_valid,
    input logic                  s_ready,
    input in_item_t              s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_item_t             m_data
);

    logic unused_ok;
    assign unused_ok = cfg_valid & cfg_ready & (|cfg_index) & (|cfg_data) & s_valid
                     & (|s_data);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_data.lit, m_data.dark, m_data.clear}))
        else $error("result flags not exclusive");

    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_rst_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind dxt_block_brightness_classifier dbbc_checker u_dbbc_checker (.*);
